// File: sv/osa_pkg.sv
// shared types, codes and state encoding for the ordered slot allocator
package osa_pkg;

  localparam int REQ_W  = 2;
  localparam int SLOT_W = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  typedef logic [REQ_W-1:0]  req_code_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [STAT_W-1:0] stat_code_t;

  localparam req_code_t REQ_ALLOC = 2'd0;
  localparam req_code_t REQ_FREE  = 2'd1;
  localparam req_code_t REQ_STEP  = 2'd2;

  localparam stat_code_t STAT_OK      = 2'd0;
  localparam stat_code_t STAT_FULL    = 2'd1;
  localparam stat_code_t STAT_END     = 2'd2;
  localparam stat_code_t STAT_NOT_OCC = 2'd3;

  typedef struct packed {
    req_code_t req_type;
    slot_t     slot;
    logic      from_head;
    value_t    entry_value;
  } osa_req_t;

  typedef struct packed {
    stat_code_t status;
    slot_t      slot;
    value_t     value;
  } osa_res_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } osa_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_A_GAP,
    ST_A_UNLINK,
    ST_A_READ_BEFORE,
    ST_A_LINK_NODE,
    ST_A_LINK_NBR,
    ST_F_CHECK,
    ST_F_WALK_START,
    ST_F_WALK,
    ST_F_LINK_NODE,
    ST_F_LINK_NBR,
    ST_S_CHECK,
    ST_S_VALUE,
    ST_RESULT
  } osa_state_t;

endpackage

// File: sv/osa_ram.sv
// single write port, single registered read port memory
module osa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/osa_seq.sv
// request sequencer: link memories, clearing pass, alloc, free walk and step
module osa_seq #(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  osa_pkg::osa_req_t   req,
  input  logic                out_free,
  output osa_pkg::osa_stat_t  stat,
  output osa_pkg::osa_res_t   res
);

  localparam int NODES = SLOTS + 4;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(SLOTS);
  localparam int GW    = $clog2(NODES + 1);

  localparam logic [NW-1:0] FREE_HEAD_N = NW'(0);
  localparam logic [NW-1:0] OCC_HEAD_N  = NW'(1);
  localparam logic [NW-1:0] TWO_N       = NW'(2);
  localparam logic [NW-1:0] FREE_TAIL_N = NW'(SLOTS + 3);
  localparam logic [NW-1:0] LAST_N      = NW'(NODES - 1);
  localparam logic [GW-1:0] NODES_G     = GW'(NODES);

  function automatic logic [NW-1:0] clamp_node(input logic [NW-1:0] n);
    return (32'(n) < NODES) ? n : FREE_TAIL_N;
  endfunction

  function automatic logic is_slot_node(input logic [NW-1:0] n);
    return (32'(n) >= 2) && (32'(n) <= SLOTS + 1);
  endfunction

  function automatic logic [NW-1:0] init_next(input logic [NW-1:0] i);
    int v;
    v = (32'(i) + 1 < NODES) ? 32'(i) + 1 : 32'(i);
    if (32'(i) == 1) v = SLOTS + 2;
    if (32'(i) == 0) v = 2;
    if (32'(i) == SLOTS + 1) v = SLOTS + 3;
    return NW'(v);
  endfunction

  function automatic logic [NW-1:0] init_prev(input logic [NW-1:0] i);
    int v;
    v = (32'(i) == 0) ? 0 : 32'(i) - 1;
    if (32'(i) == SLOTS + 2) v = 1;
    if (32'(i) == 2) v = 0;
    if (32'(i) == SLOTS + 3) v = SLOTS + 1;
    return NW'(v);
  endfunction

  osa_pkg::osa_state_t state, state_next;
  osa_pkg::osa_req_t   req_q, req_q_next;
  osa_pkg::osa_res_t   res_q, res_q_next;
  logic [NW-1:0]       node, node_next;
  logic [NW-1:0]       gap, gap_next;
  logic [NW-1:0]       aux, aux_next;
  logic [NW-1:0]       clr, clr_next;
  logic [GW-1:0]       guard, guard_next;

  logic                n_we, p_we, e_we, o_we;
  logic [NW-1:0]       n_waddr, n_wdata, n_raddr, n_rdata;
  logic [NW-1:0]       p_waddr, p_wdata, p_raddr, p_rdata;
  logic [SW-1:0]       e_waddr, e_raddr, o_waddr, o_raddr;
  logic [31:0]         e_wdata, e_rdata;
  logic [0:0]          o_wdata, o_rdata;

  logic [NW-1:0]       n_cl, p_cl, req_node;
  logic [GW-1:0]       guard_inc;
  logic                in_range;

  assign n_cl      = clamp_node(n_rdata);
  assign p_cl      = clamp_node(p_rdata);
  assign req_node  = NW'(req_q.slot) + TWO_N;
  assign guard_inc = guard + GW'(1);
  assign in_range  = 32'(req_q.slot) < SLOTS;

  osa_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata)
  );

  osa_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  osa_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_entry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  osa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_occ (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osa_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q <= req_q_next;
    res_q <= res_q_next;
    node  <= node_next;
    gap   <= gap_next;
    aux   <= aux_next;
    guard <= guard_next;
  end

  always_comb begin
    state_next = state;
    clr_next   = clr;
    req_q_next = req_q;
    res_q_next = res_q;
    node_next  = node;
    gap_next   = gap;
    aux_next   = aux;
    guard_next = guard;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
    e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;
    stat.ready     = 1'b0;
    stat.res_valid = 1'b0;

    unique case (state)
      osa_pkg::ST_CLEAR: begin
        n_we    = 1'b1;
        n_waddr = clr;
        n_wdata = init_next(clr);
        p_we    = 1'b1;
        p_waddr = clr;
        p_wdata = init_prev(clr);
        o_we    = 32'(clr) < SLOTS;
        o_waddr = SW'(clr);
        o_wdata = 1'b0;
        clr_next = clr + NW'(1);
        if (clr == LAST_N) begin
          state_next = osa_pkg::ST_IDLE;
        end
      end

      osa_pkg::ST_IDLE: begin
        stat.ready = 1'b1;
        if (start) begin
          req_q_next = req;
          state_next = osa_pkg::ST_DISPATCH;
        end
      end

      osa_pkg::ST_DISPATCH: begin
        node_next  = req_node;
        res_q_next = '{status: osa_pkg::STAT_NOT_OCC, slot: req_q.slot, value: '0};
        o_raddr    = SW'(req_q.slot);
        n_raddr    = req_node;
        p_raddr    = req_node;
        unique case (req_q.req_type)
          osa_pkg::REQ_ALLOC: begin
            n_raddr    = FREE_HEAD_N;
            state_next = osa_pkg::ST_A_GAP;
          end
          osa_pkg::REQ_FREE: begin
            state_next = in_range ? osa_pkg::ST_F_CHECK : osa_pkg::ST_RESULT;
          end
          osa_pkg::REQ_STEP: begin
            if (req_q.from_head) begin
              n_raddr    = OCC_HEAD_N;
              state_next = osa_pkg::ST_S_CHECK;
            end else begin
              state_next = in_range ? osa_pkg::ST_S_CHECK : osa_pkg::ST_RESULT;
            end
          end
          default: begin
            state_next = osa_pkg::ST_IDLE;
          end
        endcase
      end

      osa_pkg::ST_A_GAP: begin
        if (!is_slot_node(n_cl)) begin
          res_q_next = '{status: osa_pkg::STAT_FULL, slot: '0, value: '0};
          state_next = osa_pkg::ST_RESULT;
        end else begin
          gap_next   = n_cl;
          e_we       = 1'b1;
          e_waddr    = SW'(n_cl - TWO_N);
          e_wdata    = req_q.entry_value;
          o_we       = 1'b1;
          o_waddr    = SW'(n_cl - TWO_N);
          o_wdata    = 1'b1;
          n_raddr    = n_cl;
          p_raddr    = n_cl;
          state_next = osa_pkg::ST_A_UNLINK;
        end
      end

      osa_pkg::ST_A_UNLINK: begin
        n_we       = 1'b1;
        n_waddr    = p_cl;
        n_wdata    = n_cl;
        p_we       = 1'b1;
        p_waddr    = n_cl;
        p_wdata    = p_cl;
        state_next = osa_pkg::ST_A_READ_BEFORE;
      end

      osa_pkg::ST_A_READ_BEFORE: begin
        n_raddr    = gap - NW'(1);
        state_next = osa_pkg::ST_A_LINK_NODE;
      end

      osa_pkg::ST_A_LINK_NODE: begin
        aux_next   = n_cl;
        n_we       = 1'b1;
        n_waddr    = gap;
        n_wdata    = n_cl;
        p_we       = 1'b1;
        p_waddr    = gap;
        p_wdata    = gap - NW'(1);
        state_next = osa_pkg::ST_A_LINK_NBR;
      end

      osa_pkg::ST_A_LINK_NBR: begin
        n_we       = 1'b1;
        n_waddr    = gap - NW'(1);
        n_wdata    = gap;
        p_we       = 1'b1;
        p_waddr    = aux;
        p_wdata    = gap;
        res_q_next = '{status: osa_pkg::STAT_OK, slot: osa_pkg::slot_t'(gap - TWO_N), value: '0};
        state_next = osa_pkg::ST_RESULT;
      end

      osa_pkg::ST_F_CHECK: begin
        if (!o_rdata[0]) begin
          state_next = osa_pkg::ST_RESULT;
        end else begin
          n_we       = 1'b1;
          n_waddr    = p_cl;
          n_wdata    = n_cl;
          p_we       = 1'b1;
          p_waddr    = n_cl;
          p_wdata    = p_cl;
          o_we       = 1'b1;
          o_waddr    = SW'(req_q.slot);
          o_wdata    = 1'b0;
          state_next = osa_pkg::ST_F_WALK_START;
        end
      end

      osa_pkg::ST_F_WALK_START: begin
        n_raddr    = FREE_HEAD_N;
        guard_next = '0;
        state_next = osa_pkg::ST_F_WALK;
      end

      // one free-list link per cycle until the first node above the freed one
      osa_pkg::ST_F_WALK: begin
        if ((n_cl < node) && (guard_inc < NODES_G)) begin
          n_raddr    = n_cl;
          guard_next = guard_inc;
        end else begin
          aux_next   = (n_cl < node) ? FREE_TAIL_N : n_cl;
          p_raddr    = (n_cl < node) ? FREE_TAIL_N : n_cl;
          state_next = osa_pkg::ST_F_LINK_NODE;
        end
      end

      osa_pkg::ST_F_LINK_NODE: begin
        gap_next   = p_cl;
        p_we       = 1'b1;
        p_waddr    = node;
        p_wdata    = p_cl;
        n_we       = 1'b1;
        n_waddr    = node;
        n_wdata    = aux;
        state_next = osa_pkg::ST_F_LINK_NBR;
      end

      osa_pkg::ST_F_LINK_NBR: begin
        n_we       = 1'b1;
        n_waddr    = gap;
        n_wdata    = node;
        p_we       = 1'b1;
        p_waddr    = aux;
        p_wdata    = node;
        res_q_next = '{status: osa_pkg::STAT_OK, slot: req_q.slot, value: '0};
        state_next = osa_pkg::ST_RESULT;
      end

      osa_pkg::ST_S_CHECK: begin
        if (!req_q.from_head && !o_rdata[0]) begin
          state_next = osa_pkg::ST_RESULT;
        end else if (!is_slot_node(n_cl)) begin
          res_q_next = '{status: osa_pkg::STAT_END, slot: '0, value: '0};
          state_next = osa_pkg::ST_RESULT;
        end else begin
          gap_next   = n_cl;
          e_raddr    = SW'(n_cl - TWO_N);
          state_next = osa_pkg::ST_S_VALUE;
        end
      end

      osa_pkg::ST_S_VALUE: begin
        res_q_next = '{status: osa_pkg::STAT_OK, slot: osa_pkg::slot_t'(gap - TWO_N),
                       value: e_rdata};
        state_next = osa_pkg::ST_RESULT;
      end

      osa_pkg::ST_RESULT: begin
        stat.res_valid = 1'b1;
        if (out_free) begin
          state_next = osa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = osa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = res_q;

endmodule

// File: sv/ordered_slot_allocator.sv
// top level of the ordered slot allocator: input beat capture and output register
//
// A table of SLOTS value slots kept as an occupied list and a free list, both in
// index order. One request beat on the in channel gives exactly one result beat
// on the out channel, except request type 3, which is dropped without a result.
// in_stall is high while a request is being worked on; one request at a time.
// A full table, end of list or unoccupied slot answers with no link update.
// The free request walks the free list one link-memory read per cycle, so its
// time grows with the number of free slots below the freed one.
// The next request is taken from the cycle the result turns valid.
// Reset starts a clearing pass over all SLOTS + 4 nodes that rebuilds both link
// lists and clears the occupied marks; in_stall stays high until it finishes.
// The result sits in an output register; while out_stall holds it, the next
// request is still accepted and worked on, and its result waits in the
// sequencer until the output register is free.
module ordered_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  osa_pkg::req_code_t         req_type,
  input  osa_pkg::slot_t             slot,
  input  logic                       from_head,
  input  osa_pkg::value_t            entry_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output osa_pkg::stat_code_t        status,
  output osa_pkg::slot_t             result_slot,
  output osa_pkg::value_t            result_value
);

  osa_pkg::osa_req_t  req;
  osa_pkg::osa_res_t  res;
  osa_pkg::osa_stat_t stat;
  logic               start;
  logic               out_free;

  assign req      = '{req_type: req_type, slot: slot, from_head: from_head,
                      entry_value: entry_value};
  assign in_stall = !stat.ready;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  osa_seq #(.SLOTS(SLOTS)) u_seq (
    .clk(clk), .rst(rst), .start(start), .req(req), .out_free(out_free),
    .stat(stat), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && out_free) begin
      status       <= res.status;
      result_slot  <= res.slot;
      result_value <= res.value;
    end
  end

endmodule

// File: sv/osa_checker.sv
// port-level checks for the ordered slot allocator and their bind
module osa_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input osa_pkg::stat_code_t status,
  input osa_pkg::slot_t      result_slot,
  input osa_pkg::value_t     result_value,
  input logic                out_valid,
  input logic                out_stall
);

  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after accepting a beat");

  a_no_slot_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == osa_pkg::STAT_FULL || status == osa_pkg::STAT_END))
    |-> (result_slot == '0 && result_value == '0))
    else $error("full or end result carries a slot or value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(result_slot)
                                  && $stable(result_value)))
    else $error("stalled result beat changed");

endmodule

bind ordered_slot_allocator osa_checker u_osa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .status(status),
  .result_slot(result_slot), .result_value(result_value), .out_valid(out_valid),
  .out_stall(out_stall)
);
